[sv/uscd_pkg.sv]
// ============================================================================
// uscd_pkg
// Shared types, constants and tables for the seconds-to-civil-date converter.
// ============================================================================
package uscd_pkg;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_DAY,
        S_DIV_HOUR,
        S_DIV_MIN,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    // Which division the shared multiplier runs.
    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN
    } t_div_sel;

    // Divisors, and the rounded-up reciprocals that divide by them: the day
    // count is ((s >> 7) * RCP_DAY) >> 35, the hour ((r >> 4) * RCP_HOUR) >> 21
    // and the minute ((r >> 2) * RCP_MIN) >> 14, exact over each input range.
    localparam logic [25:0] DSR_DAY  = 26'd86400;
    localparam logic [25:0] DSR_HOUR = 26'd3600;
    localparam logic [25:0] DSR_MIN  = 26'd60;
    localparam logic [25:0] RCP_DAY  = 26'd50903317;
    localparam logic [25:0] RCP_HOUR = 26'd9321;
    localparam logic [25:0] RCP_MIN  = 26'd1093;

    // Epoch: 1970 is year 70 of a century whose number is 3 modulo 4.
    localparam logic [6:0] EPOCH_YOC  = 7'd70;
    localparam logic [1:0] EPOCH_CMOD = 2'd3;

    localparam logic [8:0] DAYS_LEAP   = 9'd366;
    localparam logic [8:0] DAYS_COMMON = 9'd365;
    localparam logic [3:0] MONTH_LAST  = 4'd12;
    localparam logic [3:0] MONTH_FEB   = 4'd2;

    // Controller to datapath commands.
    typedef struct packed {
        logic     load;
        logic     div_init;
        t_div_sel init_sel;
        logic     div_step;
        t_div_sel step_sel;
        logic     year_step;
        logic     month_step;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic ts_zero;
        logic div_last;
        logic year_fits;
        logic month_fits;
    } t_dp_status;

    // One result item.
    typedef struct packed {
        logic       invalid;
        logic [6:0] year_of_century;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_result;

    // Length of a month in days.
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        unique case (mon)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[sv/unix_seconds_to_civil_date.sv]
// ============================================================================
// unix_seconds_to_civil_date
// Converts a 32-bit count of seconds since 1970 into a Gregorian date and time.
// ============================================================================
// Each request carries one unsigned count of seconds since 1970-01-01 00:00:00
// and yields exactly one result: year of century, month, day, hour, minute and
// second, or the invalid flag with all other fields zero when the count is
// zero. One request is worked on at a time. For a nonzero request the
// controller runs three divisions by a constant, then subtracts one year per
// cycle for each of the Y whole years elapsed since 1970 (at most 136), then
// one month for each of the M whole months elapsed in the final year (at most
// 11). Each division first multiplies by a scaled reciprocal to form the
// quotient, then multiplies the quotient back and subtracts it to leave the
// remainder. The result sits in an output register, so the next request is
// taken while an earlier result still waits downstream.
// ============================================================================
module unix_seconds_to_civil_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] unix_seconds
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [6:0] year_of_century, [10:7] month,
                                     // [15:11] day_of_month, [20:16] hour,
                                     // [26:21] minute, [32:27] second, rest zero
    output logic        o_m_tuser    // [0] invalid
);

    uscd_pkg::t_dp_cmd    cmd;
    uscd_pkg::t_dp_status status;
    uscd_pkg::t_result    result;
    logic                 out_load;
    logic                 out_free;

    logic                 r_out_valid;
    uscd_pkg::t_result    r_out;

    // The output slot is free when empty or when its result leaves this cycle.
    assign out_free = !r_out_valid || i_m_tready;

    uscd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_ready    (o_s_tready),
        .o_out_load (out_load),
        .o_cmd      (cmd)
    );

    uscd_dp u_dp (
        .i_clk    (i_clk),
        .i_ts     (i_s_tdata),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (result)
    );

    // Output register holding one finished result until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.invalid;
    assign o_m_tdata  = {7'd0, r_out.second, r_out.minute, r_out.hour,
                         r_out.day_of_month, r_out.month, r_out.year_of_century};

endmodule

[sv/uscd_dp.sv]
// ============================================================================
// uscd_dp
// Datapath: shared reciprocal multiplier, year and month subtraction registers.
// ============================================================================
module uscd_dp (
    input  logic                  i_clk,
    input  logic [31:0]           i_ts,
    input  uscd_pkg::t_dp_cmd     i_cmd,
    output uscd_pkg::t_dp_status  o_status,
    output uscd_pkg::t_result     o_result
);

    logic [31:0] r_rem;
    logic        r_first;
    logic [15:0] r_quo;
    logic [15:0] r_days;
    logic [4:0]  r_hour;
    logic [5:0]  r_min;
    logic [6:0]  r_yoc;
    logic [1:0]  r_cmod;
    logic [3:0]  r_mon;
    logic        r_invalid;

    logic [24:0] scaled;
    logic [25:0] rcp;
    logic [25:0] dsr;
    logic [24:0] mul_a;
    logic [25:0] mul_b;
    logic [50:0] mul_p;
    logic [15:0] quo;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    always_comb begin
        case (i_cmd.step_sel)
            uscd_pkg::DIV_HOUR: begin
                scaled = {12'd0, r_rem[16:4]};
                rcp    = uscd_pkg::RCP_HOUR;
                dsr    = uscd_pkg::DSR_HOUR;
            end
            uscd_pkg::DIV_MIN: begin
                scaled = {15'd0, r_rem[11:2]};
                rcp    = uscd_pkg::RCP_MIN;
                dsr    = uscd_pkg::DSR_MIN;
            end
            default: begin
                scaled = r_rem[31:7];
                rcp    = uscd_pkg::RCP_DAY;
                dsr    = uscd_pkg::DSR_DAY;
            end
        endcase
    end

    // The first step of a division forms the quotient; the second multiplies
    // it back and takes the product off the remainder.
    assign mul_a = r_first ? scaled : {9'd0, r_quo};
    assign mul_b = r_first ? rcp : dsr;
    assign mul_p = {26'd0, mul_a} * {25'd0, mul_b};

    always_comb begin
        case (i_cmd.step_sel)
            uscd_pkg::DIV_HOUR: quo = mul_p[36:21];
            uscd_pkg::DIV_MIN:  quo = mul_p[29:14];
            default:            quo = mul_p[50:35];
        endcase
    end

    // Divisible by 4, and not a century year unless the century is a multiple of 4.
    assign leap  = (r_yoc[1:0] == 2'd0) && ((r_yoc != 7'd0) || (r_cmod == 2'd0));
    assign ylen  = leap ? uscd_pkg::DAYS_LEAP : uscd_pkg::DAYS_COMMON;
    assign mlen  = uscd_pkg::month_len(r_mon, leap);

    assign o_status.ts_zero    = (i_ts == 32'd0);
    assign o_status.div_last   = !r_first;
    assign o_status.year_fits  = (r_days < {7'd0, ylen});
    assign o_status.month_fits = (r_days < {11'd0, mlen}) || (r_mon == uscd_pkg::MONTH_LAST);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem     <= i_ts;
            r_invalid <= (i_ts == 32'd0);
            r_yoc     <= uscd_pkg::EPOCH_YOC;
            r_cmod    <= uscd_pkg::EPOCH_CMOD;
            r_mon     <= 4'd1;
        end else if (i_cmd.div_step && !r_first) begin
            r_rem <= r_rem - mul_p[31:0];
        end

        if (i_cmd.div_init) begin
            r_first <= 1'b1;
        end else if (i_cmd.div_step) begin
            r_first <= 1'b0;
        end

        if (i_cmd.div_step && r_first) begin
            r_quo <= quo;
        end

        // Capture the finished quotient on the last step of each division; year and month steps subtract from the days.
        if (i_cmd.div_step && !r_first) begin
            case (i_cmd.step_sel)
                uscd_pkg::DIV_HOUR: r_hour <= r_quo[4:0];
                uscd_pkg::DIV_MIN:  r_min  <= r_quo[5:0];
                default:            r_days <= r_quo;
            endcase
        end else if (i_cmd.year_step) begin
            r_days <= r_days - {7'd0, ylen};
        end else if (i_cmd.month_step) begin
            r_days <= r_days - {11'd0, mlen};
        end

        if (i_cmd.year_step) begin
            if (r_yoc == 7'd99) begin
                r_yoc  <= 7'd0;
                r_cmod <= r_cmod + 2'd1;
            end else begin
                r_yoc <= r_yoc + 7'd1;
            end
        end

        if (i_cmd.month_step) begin
            r_mon <= r_mon + 4'd1;
        end
    end

    always_comb begin
        o_result = '0;
        o_result.invalid = r_invalid;
        if (!r_invalid) begin
            o_result.year_of_century = r_yoc;
            o_result.month           = r_mon;
            o_result.day_of_month    = r_days[4:0] + 5'd1;
            o_result.hour            = r_hour;
            o_result.minute          = r_min;
            o_result.second          = r_rem[5:0];
        end
    end

endmodule

[sv/uscd_ctrl.sv]
// ============================================================================
// uscd_ctrl
// Controller: sequences the divisions, the year loop and the month loop.
// ============================================================================
module uscd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_out_free,
    input  uscd_pkg::t_dp_status  i_status,
    output logic                  o_ready,
    output logic                  o_out_load,
    output uscd_pkg::t_dp_cmd     o_cmd
);

    uscd_pkg::t_state r_state;
    uscd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uscd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            uscd_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = i_status.ts_zero ? uscd_pkg::S_DONE : uscd_pkg::S_DIV_DAY;
                end
            end
            uscd_pkg::S_DIV_DAY: begin
                if (i_status.div_last) n_state = uscd_pkg::S_DIV_HOUR;
            end
            uscd_pkg::S_DIV_HOUR: begin
                if (i_status.div_last) n_state = uscd_pkg::S_DIV_MIN;
            end
            uscd_pkg::S_DIV_MIN: begin
                if (i_status.div_last) n_state = uscd_pkg::S_YEAR;
            end
            uscd_pkg::S_YEAR: begin
                if (i_status.year_fits) n_state = uscd_pkg::S_MONTH;
            end
            uscd_pkg::S_MONTH: begin
                if (i_status.month_fits) n_state = uscd_pkg::S_DONE;
            end
            uscd_pkg::S_DONE: begin
                if (i_out_free) n_state = uscd_pkg::S_IDLE;
            end
            default: n_state = uscd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_ready    = 1'b0;
        o_out_load = 1'b0;
        unique case (r_state)
            uscd_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.div_init = 1'b1;
                    o_cmd.init_sel = uscd_pkg::DIV_DAY;
                end
            end
            uscd_pkg::S_DIV_DAY: begin
                o_cmd.div_step = 1'b1;
                o_cmd.step_sel = uscd_pkg::DIV_DAY;
                o_cmd.div_init = i_status.div_last;
                o_cmd.init_sel = uscd_pkg::DIV_HOUR;
            end
            uscd_pkg::S_DIV_HOUR: begin
                o_cmd.div_step = 1'b1;
                o_cmd.step_sel = uscd_pkg::DIV_HOUR;
                o_cmd.div_init = i_status.div_last;
                o_cmd.init_sel = uscd_pkg::DIV_MIN;
            end
            uscd_pkg::S_DIV_MIN: begin
                o_cmd.div_step = 1'b1;
                o_cmd.step_sel = uscd_pkg::DIV_MIN;
            end
            uscd_pkg::S_YEAR: begin
                o_cmd.year_step = !i_status.year_fits;
            end
            uscd_pkg::S_MONTH: begin
                o_cmd.month_step = !i_status.month_fits;
            end
            uscd_pkg::S_DONE: begin
                o_out_load = i_out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule
